FILE: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Holds the default sizing, the status codes, the command codes and the
// widths of the payload ports.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned ArenaBytesDef  = 4096;
  localparam int unsigned HeaderBytesDef = 13;
  localparam int unsigned PrefixBytesDef = 6;
  localparam int unsigned MaxSegmentsDef = 256;

  localparam int unsigned SizeW = 13;
  localparam int unsigned OffW  = 12;
  localparam int unsigned StW   = 3;

  typedef enum logic [StW-1:0] {
    StOk      = 3'd0,
    StZero    = 3'd1,
    StNoFit   = 3'd2,
    StUnknown = 3'd3,
    StFreed   = 3'd4
  } status_e;

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

endpackage

FILE: rtl/ffba_seg_mem.sv
// ----------------------------------------------------------------------------
// ffba_seg_mem: segment table storage
// One synchronous memory, one write port and one read port, each entry
// holding a used mark and the payload size; read data is registered.
// ----------------------------------------------------------------------------
module ffba_seg_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 14
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap allocator with coalescing
//
// Input channel (valid/ready): command, request_size, payload_offset. An
// allocate takes the first free segment whose payload is at least the
// request and splits off the remainder when it holds a header and a byte and
// the table has room. A free releases the used segment at payload_offset and
// merges it with free neighbors. Output channel (valid/ready): status,
// granted_offset, free_bytes; exactly one result transaction per input
// transaction. The segment table sits in one synchronous memory with a single
// read and a single write port. An item walks the table entry by entry
// (read, then compare), and a split or merge shifts the tail entry by entry
// (read, then write); one item is in flight at a time.
// After reset a clearing pass writes entry 0 as one free segment spanning
// the whole arena before the first transaction is taken. While the receiver
// stalls the result waits in the output register and no new item is accepted.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int unsigned ArenaBytes  = ffba_pkg::ArenaBytesDef,
  parameter int unsigned HeaderBytes = ffba_pkg::HeaderBytesDef,
  parameter int unsigned PrefixBytes = ffba_pkg::PrefixBytesDef,
  parameter int unsigned MaxSegments = ffba_pkg::MaxSegmentsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [ffba_pkg::SizeW-1:0] request_size_i,
  input  logic [ffba_pkg::OffW-1:0]  payload_offset_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ffba_pkg::StW-1:0]   status_o,
  output logic [ffba_pkg::OffW-1:0]  granted_offset_o,
  output logic [ffba_pkg::SizeW-1:0] free_bytes_o
);
  import ffba_pkg::*;

  localparam int unsigned AW   = $clog2(MaxSegments);
  localparam int unsigned CW   = $clog2(MaxSegments + 1);
  localparam int unsigned PW   = $clog2(ArenaBytes + 1) + 1;
  localparam int unsigned EW   = PW + 1;
  localparam logic [PW-1:0] Hdr  = PW'(HeaderBytes);
  localparam logic [PW-1:0] Base = PW'(PrefixBytes + HeaderBytes);
  localparam logic [PW-1:0] Init = PW'(ArenaBytes - PrefixBytes - HeaderBytes);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxSegments);

  localparam logic [3:0] SInit  = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SRd    = 4'd2;
  localparam logic [3:0] SChk   = 4'd3;
  localparam logic [3:0] SInsRd = 4'd4;
  localparam logic [3:0] SInsWr = 4'd5;
  localparam logic [3:0] SNxRd  = 4'd6;
  localparam logic [3:0] SNxChk = 4'd7;
  localparam logic [3:0] SPvRd  = 4'd8;
  localparam logic [3:0] SPvChk = 4'd9;
  localparam logic [3:0] SDelRd = 4'd10;
  localparam logic [3:0] SDelWr = 4'd11;
  localparam logic [3:0] SOut   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       cmd_q, cmd_d;
  logic [PW-1:0] req_q, req_d;
  logic [PW-1:0] off_q, off_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] ftot_q, ftot_d;
  logic [PW-1:0] cur_q, cur_d;   // size of the freed segment as it grows
  logic [CW-1:0] k_q, k_d;       // shift cursor
  logic [PW-1:0] ins_q, ins_d;   // size of split-off remainder
  logic [StW-1:0] st_q, st_d;
  logic [OffW-1:0] gnt_q, gnt_d;
  logic ov_q, ov_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic          r_used;
  logic [PW-1:0] r_size;

  assign r_used = rdata[EW-1];
  assign r_size = rdata[PW-1:0];

  ffba_seg_mem #(.Depth(MaxSegments), .Width(EW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_ready_o       = (state_q == SIdle) && !ov_q;
  assign out_valid_o      = ov_q;
  assign status_o         = st_q;
  assign granted_offset_o = gnt_q;
  assign free_bytes_o     = ftot_q[SizeW-1:0];

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; req_d = req_q; off_d = off_q; idx_d = idx_q;
    cnt_d = cnt_q; pos_d = pos_q; ftot_d = ftot_q; cur_d = cur_q;
    k_d = k_q; ins_d = ins_q; st_d = st_q; gnt_d = gnt_q; ov_d = ov_q;
    we = 1'b0; waddr = idx_q; wdata = '0; raddr = idx_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      SInit: begin
        we = 1'b1; waddr = '0; wdata = {1'b0, Init};
        state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i && !ov_q) begin
          cmd_d = command_i;
          req_d = PW'(request_size_i);
          off_d = PW'(payload_offset_i);
          idx_d = '0; pos_d = Base; gnt_d = '0;
          if (command_i == CmdAlloc && request_size_i == '0) begin
            st_d = StZero; state_d = SOut;
          end else begin
            state_d = SRd;
          end
        end
      end
      SRd: begin
        raddr = idx_q;
        state_d = SChk;
      end
      SChk: begin
        if (cmd_q == CmdAlloc) begin
          if (!r_used && r_size >= req_q) begin
            st_d = StOk; gnt_d = pos_q[OffW-1:0];
            we = 1'b1; waddr = idx_q;
            if (r_size >= req_q + Hdr + PW'(1) && cnt_q < MaxCnt) begin
              wdata = {1'b1, req_q};
              ftot_d = ftot_q - req_q - Hdr;
              ins_d = r_size - req_q - Hdr;
              k_d = cnt_q;
              cnt_d = cnt_q + CW'(1);
              state_d = SInsRd;
            end else begin
              wdata = {1'b1, r_size};
              ftot_d = ftot_q - r_size;
              state_d = SOut;
            end
          end else if (CW'(idx_q) + CW'(1) >= cnt_q) begin
            st_d = StNoFit; state_d = SOut;
          end else begin
            pos_d = pos_q + r_size + Hdr;
            idx_d = idx_q + AW'(1);
            state_d = SRd;
          end
        end else begin
          if (pos_q == off_q) begin
            if (!r_used) begin
              st_d = StFreed; state_d = SOut;
            end else begin
              st_d = StOk;
              ftot_d = ftot_q + r_size;
              cur_d = r_size;
              we = 1'b1; waddr = idx_q; wdata = {1'b0, r_size};
              if (CW'(idx_q) + CW'(1) < cnt_q) begin
                state_d = SNxRd;
              end else begin
                state_d = SPvRd;
              end
            end
          end else if (CW'(idx_q) + CW'(1) >= cnt_q) begin
            st_d = StUnknown; state_d = SOut;
          end else begin
            pos_d = pos_q + r_size + Hdr;
            idx_d = idx_q + AW'(1);
            state_d = SRd;
          end
        end
      end
      // shift entries [idx+1 .. cnt-2] up by one, from the top down
      SInsRd: begin
        if (k_q > CW'(idx_q) + CW'(1)) begin
          raddr = AW'(k_q - CW'(1));
          state_d = SInsWr;
        end else begin
          we = 1'b1; waddr = idx_q + AW'(1); wdata = {1'b0, ins_q};
          state_d = SOut;
        end
      end
      SInsWr: begin
        we = 1'b1; waddr = AW'(k_q); wdata = rdata;
        k_d = k_q - CW'(1);
        state_d = SInsRd;
      end
      SNxRd: begin
        raddr = idx_q + AW'(1);
        state_d = SNxChk;
      end
      SNxChk: begin
        if (!r_used) begin
          cur_d = cur_q + Hdr + r_size;
          ftot_d = ftot_q + Hdr;
          we = 1'b1; waddr = idx_q; wdata = {1'b0, cur_q + Hdr + r_size};
          k_d = CW'(idx_q) + CW'(1);
          state_d = SDelRd;
        end else begin
          state_d = SPvRd;
        end
      end
      SPvRd: begin
        if (idx_q != '0) begin
          raddr = idx_q - AW'(1);
          state_d = SPvChk;
        end else begin
          state_d = SOut;
        end
      end
      SPvChk: begin
        if (!r_used) begin
          ftot_d = ftot_q + Hdr;
          we = 1'b1; waddr = idx_q - AW'(1);
          wdata = {1'b0, r_size + Hdr + cur_q};
          idx_d = idx_q - AW'(1);
          cur_d = r_size + Hdr + cur_q;
          k_d = CW'(idx_q);
          state_d = SDelRd;
        end else begin
          state_d = SOut;
        end
      end
      // drop entry k: move [k+1 .. cnt-1] down by one
      SDelRd: begin
        if (k_q + CW'(1) < cnt_q) begin
          raddr = AW'(k_q + CW'(1));
          state_d = SDelWr;
        end else begin
          cnt_d = cnt_q - CW'(1);
          // look at the previous neighbor; after a backward merge it is used
          state_d = SPvRd;
        end
      end
      SDelWr: begin
        we = 1'b1; waddr = AW'(k_q); wdata = rdata;
        k_d = k_q + CW'(1);
        state_d = SDelRd;
      end
      SOut: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      cnt_q   <= CW'(1);
      ftot_q  <= Init;
      ov_q    <= 1'b0;
      idx_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ftot_q  <= ftot_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; req_q <= req_d; off_q <= off_d; pos_q <= pos_d;
    cur_q <= cur_d; ins_q <= ins_d; st_q <= st_d; gnt_q <= gnt_d;
  end

  ap_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new item taken while one is in flight");
  ap_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= MaxCnt))
    else $error("segment count out of range");
  ap_err_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (granted_offset_o == '0))
    else $error("grant on error");
  ap_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ftot_q <= Init)
    else $error("free total above arena");

endmodule
